// File: rtl/assert_macros.svh
// Assertion helpers used by the datapath RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition must never be true.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/unst_pkg.sv
`default_nettype none

package unst_pkg;

  // Default sizing
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_BITS_DEF  = 64;
  localparam int MAX_RESULTS   = 16;

  // Port field widths
  localparam int KEY_PORT_BITS = 64;
  localparam int SLOT_BITS     = 4;
  localparam int IN_DATA_BITS  = 72;
  localparam int OUT_DATA_BITS = 72;

  // Request modes
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;
  localparam logic [1:0] MODE_LIST   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_EXISTS   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FOUND    = 3'd5;
  localparam logic [2:0] ST_ENTRY    = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  // Controller to datapath
  typedef struct packed {
    logic       accept;   // capture request, restart scan index
    logic       scan;     // read next stored key and compare previous
    logic       latch;    // record scan outcome
    logic       del_rd;   // read the last stored entry
    logic       list_rd;  // read entry at the list index
    logic       emit;     // load the result register
    logic [2:0] code;     // status of the emitted result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;        // registered key matches request
    logic done;       // scan reached the fill count without a match
    logic found;      // latched scan outcome
    logic full;       // table at capacity
    logic empty;      // table holds no entry
    logic list_last;  // current list entry is the final one emitted
    logic out_free;   // result register can take a transaction
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/unst_ctrl.sv
`default_nettype none

module unst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_mode,
  output logic               in_ready,
  output unst_pkg::cmd_t     cmd,
  input  wire unst_pkg::stat_t stat
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_RESULT    = 3'd2;
  localparam logic [2:0] S_DEL_RD    = 3'd3;
  localparam logic [2:0] S_DEL_WR    = 3'd4;
  localparam logic [2:0] S_LIST_RD   = 3'd5;
  localparam logic [2:0] S_LIST_EMIT = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] mode, mode_next;

  // Sequence one request at a time
  always_comb begin
    state_next = state;
    mode_next  = mode;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          mode_next  = in_mode;
          if (in_mode == unst_pkg::MODE_LIST) begin
            state_next = stat.empty ? S_RESULT : S_LIST_RD;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.done) begin
          cmd.latch  = 1'b1;
          state_next = (stat.hit && mode == unst_pkg::MODE_DELETE) ? S_DEL_RD : S_RESULT;
        end
      end
      S_RESULT: begin
        case (mode)
          unst_pkg::MODE_CREATE: begin
            if (stat.found) begin
              cmd.code = unst_pkg::ST_EXISTS;
            end else if (stat.full) begin
              cmd.code = unst_pkg::ST_FULL;
            end else begin
              cmd.code = unst_pkg::ST_CREATED;
            end
          end
          unst_pkg::MODE_DELETE: cmd.code = unst_pkg::ST_NOTFOUND;
          unst_pkg::MODE_SEARCH: begin
            cmd.code = stat.found ? unst_pkg::ST_FOUND : unst_pkg::ST_NOTFOUND;
          end
          default: cmd.code = unst_pkg::ST_EMPTY;
        endcase
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DEL_RD: begin
        cmd.del_rd = 1'b1;
        state_next = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.code = unst_pkg::ST_DELETED;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LIST_RD: begin
        cmd.list_rd = 1'b1;
        state_next  = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        cmd.code = unst_pkg::ST_ENTRY;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.list_last ? S_IDLE : S_LIST_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and request mode
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= unst_pkg::MODE_CREATE;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/unst_dp.sv
`default_nettype none
`include "assert_macros.svh"

module unst_dp #(
  parameter int CAPACITY = unst_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = unst_pkg::KEY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [unst_pkg::KEY_PORT_BITS-1:0] in_key,
  input  wire unst_pkg::cmd_t                    cmd,
  output unst_pkg::stat_t                        stat,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [2:0]                             out_status,
  output logic [unst_pkg::SLOT_BITS-1:0]         out_slot,
  output logic [unst_pkg::KEY_PORT_BITS-1:0]     out_name,
  output logic                                   out_last
);

  localparam int IW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int SlotW    = unst_pkg::SLOT_BITS;
  localparam int KeyPortW = unst_pkg::KEY_PORT_BITS;
  localparam int ListMaxI = (CAPACITY < unst_pkg::MAX_RESULTS) ? CAPACITY
                                                                : unst_pkg::MAX_RESULTS;
  localparam logic [CW-1:0] CountMax = CW'(CAPACITY);
  localparam logic [CW-1:0] ListMax  = CW'(ListMaxI);

  logic [KEY_BITS-1:0] mem [CAPACITY];

  logic [CW-1:0]       count;
  logic [KEY_BITS-1:0] key;
  logic [CW-1:0]       idx;
  logic [KEY_BITS-1:0] rd_data;
  logic [IW-1:0]       rd_pos;
  logic                rd_vld;
  logic                found;
  logic [IW-1:0]       match_pos;

  logic [CW-1:0]       list_n;
  logic [CW-1:0]       idx_inc;
  logic [CW-1:0]       count_m1;
  logic                in_range;
  logic                out_free;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic                is_create;
  logic                is_delete;
  logic                is_entry;

  logic [SlotW-1:0]    slot_next;
  logic [KeyPortW-1:0] name_next;
  logic                last_next;

  // Decode status from registered state and the output ready
  always_comb begin
    list_n    = (count < ListMax) ? count : ListMax;
    idx_inc   = idx + CW'(1);
    count_m1  = count - CW'(1);
    in_range  = (idx < count);
    out_free  = !out_valid || out_ready;

    stat.hit       = rd_vld && (rd_data == key);
    stat.done      = !rd_vld && !in_range;
    stat.found     = found;
    stat.full      = (count >= CountMax);
    stat.empty     = (count == '0);
    stat.list_last = (idx_inc == list_n);
    stat.out_free  = out_free;
  end

  // Decode memory port controls
  always_comb begin
    is_create = cmd.emit && (cmd.code == unst_pkg::ST_CREATED);
    is_delete = cmd.emit && (cmd.code == unst_pkg::ST_DELETED);
    is_entry  = cmd.emit && (cmd.code == unst_pkg::ST_ENTRY);

    rd_en   = (cmd.scan && in_range) || cmd.list_rd || cmd.del_rd;
    rd_addr = cmd.del_rd ? count_m1[IW-1:0] : idx[IW-1:0];
    wr_en   = is_create || is_delete;
    wr_addr = is_create ? count[IW-1:0] : match_pos;
    wr_data = is_create ? key : rd_data;
  end

  // Store keys, register read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Track scan position and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx    <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= in_range;
        if (in_range) begin
          idx <= idx_inc;
        end
      end else if (is_entry) begin
        idx <= idx_inc;
      end
      if (is_create) begin
        count <= count + CW'(1);
      end else if (is_delete) begin
        count <= count_m1;
      end
    end
  end

  // Capture request key, scan position and outcome
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key <= in_key[KEY_BITS-1:0];
    end
    if (cmd.scan && in_range) begin
      rd_pos <= idx[IW-1:0];
    end
    if (cmd.latch) begin
      found     <= stat.hit;
      match_pos <= rd_pos;
    end
  end

  // Form result fields from status code
  always_comb begin
    case (cmd.code)
      unst_pkg::ST_CREATED: slot_next = SlotW'(count);
      unst_pkg::ST_EXISTS,
      unst_pkg::ST_DELETED,
      unst_pkg::ST_FOUND:   slot_next = SlotW'(match_pos);
      unst_pkg::ST_ENTRY:   slot_next = SlotW'(idx);
      default:              slot_next = '0;
    endcase
    case (cmd.code)
      unst_pkg::ST_ENTRY: name_next = KeyPortW'(rd_data);
      unst_pkg::ST_EMPTY: name_next = '0;
      default:            name_next = KeyPortW'(key);
    endcase
    last_next = (cmd.code == unst_pkg::ST_ENTRY) ? stat.list_last : 1'b1;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.code;
      out_slot   <= slot_next;
      out_name   <= name_next;
      out_last   <= last_next;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, count > CountMax)
  `ASSERT_NEVER(a_emit_free, clk, rst, cmd.emit && !out_free)
  `ASSERT_IMPLIES(a_create_room, clk, rst, is_create, count < CountMax)
  `ASSERT_IMPLIES(a_delete_hit, clk, rst, is_delete, found && count != '0)

endmodule

`default_nettype wire

// File: rtl/unique_name_set_table_top.sv
// Create, delete and search: one result, given once the key scan has ended;
//   the scan reads one stored entry per cycle from the name memory.
// List: each entry is read from memory, then loaded as a result; up to 16 entries.
// A new request is taken once the final result of the previous one is registered.
// Synchronous active-high reset empties the table; stored keys are not cleared.
`default_nettype none

module unique_name_set_table_top #(
  parameter int CAPACITY = unst_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = unst_pkg::KEY_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [1:0] mode, [65:2] key_name, [71:66] zero
  input  wire logic [unst_pkg::IN_DATA_BITS-1:0]  s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [2:0] status, [6:3] slot, [70:7] entry_name, [71] zero
  output logic [unst_pkg::OUT_DATA_BITS-1:0]      m_tdata,
  output logic                                    m_tlast
);

  localparam int KeyW  = unst_pkg::KEY_PORT_BITS;
  localparam int SlotW = unst_pkg::SLOT_BITS;

  unst_pkg::cmd_t  cmd;
  unst_pkg::stat_t stat;

  logic [2:0]       out_status;
  logic [SlotW-1:0] out_slot;
  logic [KeyW-1:0]  out_name;

  unst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tdata[1:0]),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  unst_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_key     (s_tdata[KeyW+1:2]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_name   (out_name),
    .out_last   (m_tlast)
  );

  // Pack result fields
  assign m_tdata = {1'b0, out_name, out_slot, out_status};

endmodule

`default_nettype wire
